@@ hw/rtl/csvti_pkg.sv @@
// ----------------------------------------------------------------------------
// csvti_pkg - shared types, constants and functions for CSV type inference
// Field classes, per-field classifier state and the byte/field helpers.
// ----------------------------------------------------------------------------
package csvti_pkg;

  // Field / column class encoding
  typedef enum logic [2:0] {
    FT_UNKNOWN = 3'd0,
    FT_STRING  = 3'd1,
    FT_INTEGER = 3'd2,
    FT_FLOAT   = 3'd3,
    FT_BOOLEAN = 3'd4,
    FT_EMPTY   = 3'd5
  } ftype_t;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_ROWS  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 8'd1;

  localparam logic [15:0] SAMPLE_ROWS_RST  = 16'd100;
  localparam logic [7:0]  COLUMN_COUNT_RST = 8'd128;
  localparam logic [15:0] ROWS_MAX         = 16'hFFFF;

  // Keywords: true, false, yes, no, 1, 0
  localparam int KW_COUNT = 6;
  localparam int KW_CHARS = 5;
  localparam logic [7:0] KW_TEXT [KW_COUNT][KW_CHARS] = '{
    '{8'h74, 8'h72, 8'h75, 8'h65, 8'h00},   // true
    '{8'h66, 8'h61, 8'h6C, 8'h73, 8'h65},   // false
    '{8'h79, 8'h65, 8'h73, 8'h00, 8'h00},   // yes
    '{8'h6E, 8'h6F, 8'h00, 8'h00, 8'h00},   // no
    '{8'h31, 8'h00, 8'h00, 8'h00, 8'h00},   // 1
    '{8'h30, 8'h00, 8'h00, 8'h00, 8'h00}    // 0
  };
  localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd4, 3'd5, 3'd3, 3'd2, 3'd1, 3'd1};

  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_CASE    = 8'h20;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [2:0] POS_MAX    = 3'd7;

  // Per-field classifier state
  typedef struct packed {
    logic [2:0] pos;
    logic [5:0] cand;
    logic       sign_ok;
    logic       digit;
    logic       dot;
    logic       int_ok;
    logic       flt_ok;
  } fstate_t;

  localparam fstate_t FSTATE_RST = '{
    pos: 3'd0, cand: 6'h3F, sign_ok: 1'b1, digit: 1'b0,
    dot: 1'b0, int_ok: 1'b1, flt_ok: 1'b1
  };

  // Fold one byte into the field state
  function automatic fstate_t take_byte(fstate_t s, logic [7:0] c);
    fstate_t    n;
    logic [7:0] lc;
    n  = s;
    lc = (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + CH_CASE : c;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (s.pos >= KW_LEN[k]) begin
        n.cand[k] = 1'b0;
      end else if (KW_TEXT[k][s.pos] != lc) begin
        n.cand[k] = 1'b0;
      end
    end
    if (c >= CH_ZERO && c <= CH_NINE) begin
      n.digit = 1'b1;
    end else if ((c == CH_PLUS || c == CH_MINUS) && s.sign_ok) begin
      n.digit = s.digit;  // leading sign
    end else if (c == CH_DOT) begin
      n.int_ok = 1'b0;
      if (s.dot) begin
        n.flt_ok = 1'b0;
      end else begin
        n.dot = 1'b1;
      end
    end else begin
      n.int_ok = 1'b0;
      n.flt_ok = 1'b0;
    end
    n.sign_ok = 1'b0;
    if (s.pos != POS_MAX) begin
      n.pos = s.pos + 3'd1;
    end
    return n;
  endfunction

  // Class of a finished, non-empty field
  function automatic ftype_t classify(fstate_t s);
    logic kw_hit;
    kw_hit = 1'b0;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (s.cand[k] && s.pos == KW_LEN[k]) begin
        kw_hit = 1'b1;
      end
    end
    if (kw_hit) begin
      return FT_BOOLEAN;
    end else if (s.int_ok && s.digit) begin
      return FT_INTEGER;
    end else if (s.flt_ok && s.dot) begin
      return FT_FLOAT;
    end
    return FT_STRING;
  endfunction

  // Column type merge
  function automatic ftype_t merge_type(ftype_t cur, ftype_t ft);
    if (cur == FT_UNKNOWN || cur == FT_EMPTY) begin
      return ft;
    end else if (cur != FT_STRING && ft != cur && ft != FT_EMPTY) begin
      return FT_STRING;
    end
    return cur;
  endfunction

endpackage

@@ hw/rtl/csvti_ram.sv @@
// ----------------------------------------------------------------------------
// csvti_ram - simple dual-port RAM
// One write port, one read port with enable and registered read data.
// ----------------------------------------------------------------------------
module csvti_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/csv_field_type_inference_unit.sv @@
// ----------------------------------------------------------------------------
// csv_field_type_inference_unit - per-column type inference for delimited text
// Classifies each field as empty/boolean/integer/float/string from its bytes
// and merges the class into a per-column type table.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_stall  | in_column, in_char_code, in_no_chars,
//          |                      | in_field_end, in_row_end
//  out     | out_valid / out_stall| out_column, out_field_type,
//          |                      | out_column_type, out_updated
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  One input beat per cycle while in_stall is low. A beat that ends a field gives
//  one result beat, registered through classify -> table merge -> output register.
//  After reset the column table is swept to unknown over all MAX_COLS entries;
//  in_stall is held high during the sweep, cfg writes are taken throughout.
//  Apart from the sweep, in_stall rises only while a result is held in the output
//  register and the merge stage is also full; it never depends on in_valid.
//
module csv_field_type_inference_unit #(
  parameter int MAX_COLS = 128
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input beats
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [6:0]                           in_column,
  input  logic [7:0]                           in_char_code,
  input  logic                                 in_no_chars,
  input  logic                                 in_field_end,
  input  logic                                 in_row_end,
  // result beats
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [6:0]                           out_column,
  output csvti_pkg::ftype_t                    out_field_type,
  output csvti_pkg::ftype_t                    out_column_type,
  output logic                                 out_updated,
  // configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [csvti_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [csvti_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import csvti_pkg::*;

  localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam logic [AW-1:0] CLR_LAST = AW'(MAX_COLS - 1);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [15:0] sample_rows_r;
  logic [7:0]  column_count_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_rows_r  <= SAMPLE_ROWS_RST;
      column_count_r <= COLUMN_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SAMPLE_ROWS:  sample_rows_r  <= cfg_data;
        REG_COLUMN_COUNT: column_count_r <= cfg_data[7:0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Table clearing sweep after reset
  // --------------------------------------------------------------------------
  logic          clr_active_r;
  logic [AW-1:0] clr_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_idx_r    <= '0;
    end else if (clr_active_r) begin
      if (clr_idx_r == CLR_LAST) begin
        clr_active_r <= 1'b0;
      end
      clr_idx_r <= clr_idx_r + AW'(1);
    end
  end

  // --------------------------------------------------------------------------
  // Handshake / stage control
  // --------------------------------------------------------------------------
  logic s1_valid_r;
  logic out_valid_r;
  logic s1_fire;
  logic in_fire;
  logic in_ends;

  assign s1_fire  = s1_valid_r && !(out_valid_r && out_stall);
  assign in_stall = clr_active_r || (s1_valid_r && out_valid_r && out_stall);
  assign in_fire  = in_valid && !in_stall;
  assign in_ends  = in_no_chars || in_field_end;

  // --------------------------------------------------------------------------
  // Stage 0: per-byte classifier, updated on every accepted beat
  // --------------------------------------------------------------------------
  fstate_t fst_r;
  fstate_t fst_byte;
  ftype_t  in_ftype;

  always_comb begin
    fst_byte = take_byte(fst_r, in_char_code);
    in_ftype = in_no_chars ? FT_EMPTY : classify(fst_byte);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fst_r <= FSTATE_RST;
    end else if (in_fire) begin
      fst_r <= in_ends ? FSTATE_RST : fst_byte;
    end
  end

  // --------------------------------------------------------------------------
  // Column table: read issued on acceptance, written by the sweep and the merge stage
  // --------------------------------------------------------------------------
  logic [31:0]   in_col_ext;
  logic [31:0]   s1_col_ext;
  logic [AW-1:0] ram_waddr;
  logic [2:0]    ram_wdata;
  logic          ram_we;
  logic [2:0]    ram_rdata;

  logic [6:0]    s1_col_r;
  ftype_t        s1_ftype_r;
  logic          s1_rend_r;

  ftype_t        cur_type;
  ftype_t        merged;
  ftype_t        col_type;
  logic          in_range;
  logic          sampling;
  logic          upd;

  assign in_col_ext = 32'(in_column);
  assign s1_col_ext = 32'(s1_col_r);

  assign ram_we    = clr_active_r || (s1_fire && upd);
  assign ram_waddr = clr_active_r ? clr_idx_r : s1_col_ext[AW-1:0];
  assign ram_wdata = clr_active_r ? FT_UNKNOWN : merged;

  csvti_ram #(
    .WIDTH (3),
    .DEPTH (MAX_COLS),
    .AW    (AW)
  ) u_col_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_fire),
    .raddr (in_col_ext[AW-1:0]),
    .rdata (ram_rdata)
  );

  // bypass: last table write, covers a read that raced the write
  logic       byp_valid_r;
  logic [6:0] byp_col_r;
  ftype_t     byp_type_r;

  always_ff @(posedge clk) begin
    if (!rst_n || clr_active_r) begin
      byp_valid_r <= 1'b0;
    end else if (s1_fire && upd) begin
      byp_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && upd) begin
      byp_col_r  <= s1_col_r;
      byp_type_r <= merged;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: merge into the column table
  // --------------------------------------------------------------------------
  logic [15:0] rows_sampled_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= (in_fire && in_ends) || (s1_valid_r && !s1_fire);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_ends) begin
      s1_col_r   <= in_column;
      s1_ftype_r <= in_ftype;
      s1_rend_r  <= in_row_end;
    end
  end

  always_comb begin
    if (byp_valid_r && byp_col_r == s1_col_r) begin
      cur_type = byp_type_r;
    end else begin
      cur_type = ftype_t'(ram_rdata);
    end
    in_range = ({1'b0, s1_col_r} < column_count_r) && (s1_col_ext < 32'(MAX_COLS));
    sampling = rows_sampled_r < sample_rows_r;
    merged   = merge_type(cur_type, s1_ftype_r);
    upd      = in_range && sampling;
    if (!in_range) begin
      col_type = FT_UNKNOWN;
    end else if (sampling) begin
      col_type = merged;
    end else begin
      col_type = cur_type;
    end
  end

  // row counter keeps running (saturating) after the table freezes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_sampled_r <= '0;
    end else if (s1_fire && s1_rend_r && rows_sampled_r != ROWS_MAX) begin
      rows_sampled_r <= rows_sampled_r + 16'd1;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic [6:0] out_col_r;
  ftype_t     out_ftype_r;
  ftype_t     out_ctype_r;
  logic       out_upd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s1_fire || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_col_r   <= s1_col_r;
      out_ftype_r <= s1_ftype_r;
      out_ctype_r <= col_type;
      out_upd_r   <= upd;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_column      = out_col_r;
  assign out_field_type  = out_ftype_r;
  assign out_column_type = out_ctype_r;
  assign out_updated     = out_upd_r;

endmodule
